// ===== rtl/pwl_pkg.sv =====
package pwl_pkg;
  typedef enum logic {
    REQ_LOAD  = 1'b0,
    REQ_QUERY = 1'b1
  } req_e;

  // word handed from one search cell to the next
  typedef struct packed {
    logic        active;
    logic        found;
    logic [7:0]  pos;
    logic [31:0] q;
  } srch_t;
endpackage

// ===== rtl/pwl_cell.sv =====
module pwl_cell #(
  parameter int unsigned IdxW = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                wr_i,
  input  logic [31:0]         x_i,
  input  logic [31:0]         y_i,
  input  logic [31:0]         xn_i,
  input  logic                last_i,
  input  logic [IdxW-1:0]     my_idx_i,
  input  pwl_pkg::srch_t      s_i,
  output pwl_pkg::srch_t      s_o,
  output logic [31:0]         x_o,
  output logic [31:0]         y_o
);
  import pwl_pkg::*;
  logic [31:0] x_q, y_q;
  logic        hit;
  srch_t       s_q, s_d;

  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      x_q <= x_i;
      y_q <= y_i;
    end
  end

  // a cell past the last segment passes the word on unchanged
  assign hit = !last_i && (($signed(s_i.q) == $signed(x_q)) ||
               (($signed(s_i.q) > $signed(x_q)) && ($signed(s_i.q) < $signed(xn_i))));

  always_comb begin
    s_d = s_i;
    if (s_i.active && hit) begin
      s_d.found = 1'b1;
      s_d.pos   = 8'(my_idx_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_q.active <= 1'b0;
      s_q.found  <= 1'b0;
      s_q.pos    <= '0;
      s_q.q      <= '0;
    end else begin
      s_q <= s_d;
    end
  end

  assign s_o = s_q;
  assign x_o = x_q;
  assign y_o = y_q;
endmodule

// ===== rtl/pwl_div.sv =====
module pwl_div (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [63:0]  num_i,
  input  logic [31:0]  den_i,
  output logic         done_o,
  output logic [39:0]  quo_o,
  output logic         big_o
);
  import pwl_pkg::*;
  logic [63:0] num_q;
  logic [32:0] rem_q;
  logic [31:0] den_q;
  logic [39:0] quo_q;
  logic        big_q, busy_q, done_q;
  logic [5:0]  cnt_q;
  logic [33:0] sh;
  logic [33:0] diff;

  assign sh   = {rem_q, num_q[63]};
  assign diff = sh - {2'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= !start_i && busy_q && (cnt_q == 6'd0);
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= 6'd63;
        num_q  <= num_i;
        den_q  <= den_i;
        rem_q  <= '0;
        quo_q  <= '0;
        big_q  <= 1'b0;
      end else if (busy_q) begin
        num_q <= {num_q[62:0], 1'b0};
        if (!diff[33]) begin
          rem_q <= diff[32:0];
          if (cnt_q >= 6'd40) big_q <= 1'b1;
          else quo_q <= {quo_q[38:0], 1'b1};
        end else begin
          rem_q <= sh[32:0];
          if (cnt_q < 6'd40) quo_q <= {quo_q[38:0], 1'b0};
        end
        cnt_q <= cnt_q - 6'd1;
        if (cnt_q == 6'd0) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;
  assign big_o  = big_q;
endmodule

// ===== rtl/piecewise_linear_table_interp.sv =====
// Load words are written into the addressed cell. A query walks the row of TABLE_DEPTH
// search cells (one per cycle), then operand fetch, a 32x32 product, a divider start
// and a 64-step restoring divider. A query at or past the last point returns that
// point's y after the search; a zero-width segment returns its right y with no divide.
// One query in flight; a new word can be taken in the cycle after the result is taken.
// Reset clears control and sets used_points to 16; table contents stay undefined.
module piecewise_linear_table_interp #(
  parameter int unsigned TABLE_DEPTH = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // entry_index[3:0], point_x[35:4], point_y[67:36], query_value[99:68], pad
  input  logic [103:0] s_axis_tdata,
  // req_type
  input  logic         s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // interp_value[31:0], segment_index[35:32], pad
  output logic [39:0]  m_axis_tdata,
  // saturated
  output logic         m_axis_tuser,
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [4:0]   cfg_data_i
);
  import pwl_pkg::*;
  localparam int unsigned IdxW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [2:0] {
    ST_IDLE, ST_SRCH, ST_MUL, ST_DIV, ST_OUT
  } state_e;

  state_e      state_q;
  logic [4:0]  used_q;
  logic [CntW-1:0] n_eff;
  logic [IdxW-1:0] last_idx;
  logic        in_acc;
  logic [3:0]  e_idx;
  logic [31:0] px, py, qv;
  srch_t       chain [TABLE_DEPTH+1];
  logic [31:0] cx [TABLE_DEPTH];
  logic [31:0] cy [TABLE_DEPTH];
  logic [CntW-1:0] cnt_q;
  logic [31:0] q_q, y0_q, y1_q, x0_q;
  logic [7:0]  pos_q;
  logic        neg_q, last_q, zero_q;
  logic [63:0] prod_q;
  logic [31:0] dx_q;
  logic        div_start, div_done, div_big;
  logic        div_go_q;
  logic [39:0] div_quo;
  logic [31:0] res_q;
  logic        sat_q;

  assign e_idx = s_axis_tdata[3:0];
  assign px    = s_axis_tdata[35:4];
  assign py    = s_axis_tdata[67:36];
  assign qv    = s_axis_tdata[99:68];

  assign s_axis_tready = (state_q == ST_IDLE);
  assign cfg_ready_o   = (state_q == ST_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    if (used_q < 5'd2) n_eff = CntW'(2);
    else if (32'(used_q) > TABLE_DEPTH) n_eff = CntW'(TABLE_DEPTH);
    else n_eff = CntW'(used_q);
  end

  assign last_idx = IdxW'(n_eff - CntW'(1));

  assign chain[0].active = in_acc && (s_axis_tuser == REQ_QUERY);
  assign chain[0].found  = 1'b0;
  assign chain[0].pos    = '0;
  assign chain[0].q      = qv;

  for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
    logic [31:0] xn;
    if (g + 1 < TABLE_DEPTH) begin : g_n
      assign xn = cx[g+1];
    end else begin : g_l
      assign xn = cx[g];
    end
    pwl_cell #(.IdxW(IdxW)) u_cell (
      .clk_i, .rst_ni,
      .wr_i     (in_acc && (s_axis_tuser == REQ_LOAD) && (32'(e_idx) == g)),
      .x_i      (px),
      .y_i      (py),
      .xn_i     (xn),
      .last_i   (32'(g) + 1 >= 32'(n_eff)),
      .my_idx_i (IdxW'(g)),
      .s_i      (chain[g]),
      .s_o      (chain[g+1]),
      .x_o      (cx[g]),
      .y_o      (cy[g])
    );
  end

  function automatic logic [31:0] mag(input logic [32:0] v);
    mag = v[32] ? 32'(-v) : v[31:0];
  endfunction

  logic [32:0] dy_w, dq_w;
  assign dy_w = {y1_q[31], y1_q} - {y0_q[31], y0_q};
  assign dq_w = {q_q[31], q_q} - {x0_q[31], x0_q};

  logic [32:0] dxs;
  logic [31:0] x1_s;
  assign x1_s = cx[pos_q[IdxW-1:0] + IdxW'(1)];
  assign dxs  = {x1_s[31], x1_s} - {x0_q[31], x0_q};

  // divider start is taken on the cycle after the product is stored
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_go_q <= 1'b0;
    end else begin
      div_go_q <= (state_q == ST_DIV) && !zero_q && (dxs != '0);
    end
  end

  assign div_start = div_go_q;

  pwl_div u_div (
    .clk_i, .rst_ni,
    .start_i (div_start),
    .num_i   (prod_q),
    .den_i   (dx_q),
    .done_o  (div_done),
    .quo_o   (div_quo),
    .big_o   (div_big)
  );

  logic [41:0] sum_w;
  assign sum_w = neg_q ? {{10{y0_q[31]}}, y0_q} - {2'b0, div_quo}
                       : {{10{y0_q[31]}}, y0_q} + {2'b0, div_quo};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      used_q  <= 5'd16;
      cnt_q   <= '0;
      sat_q   <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) used_q <= cfg_data_i;
      case (state_q)
        ST_IDLE: begin
          if (chain[0].active) begin
            state_q <= ST_SRCH;
            cnt_q   <= '0;
            q_q     <= qv;
            last_q  <= ($signed(qv) >= $signed(cx[last_idx]));
          end
        end
        ST_SRCH: begin
          cnt_q <= cnt_q + CntW'(1);
          if (32'(cnt_q) == TABLE_DEPTH - 1) begin
            if (last_q) begin
              pos_q   <= 8'(last_idx);
              res_q   <= cy[last_idx];
              sat_q   <= 1'b0;
              state_q <= ST_OUT;
            end else begin
              pos_q   <= chain[TABLE_DEPTH].found ? chain[TABLE_DEPTH].pos : 8'd0;
              state_q <= ST_MUL;
              zero_q  <= 1'b1;
            end
          end
        end
        ST_MUL: begin
          if (zero_q) begin
            // fetch operands of the chosen segment
            x0_q   <= cx[pos_q[IdxW-1:0]];
            y0_q   <= cy[pos_q[IdxW-1:0]];
            y1_q   <= cy[pos_q[IdxW-1:0] + IdxW'(1)];
            zero_q <= 1'b0;
            state_q <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (!zero_q) begin
            if (dxs == '0) begin
              res_q   <= y1_q;
              sat_q   <= 1'b0;
              state_q <= ST_OUT;
            end else begin
              prod_q <= 64'(mag(dy_w)) * 64'(mag(dq_w));
              dx_q   <= mag(dxs);
              neg_q  <= (dy_w[32] != dq_w[32]) != dxs[32];
              zero_q <= 1'b1;
            end
          end else if (div_done) begin
            if (div_big || sum_w[41:31] != {11{sum_w[31]}}) begin
              sat_q <= 1'b1;
              res_q <= (div_big ? neg_q : sum_w[41]) ? 32'h8000_0000 : 32'h7FFF_FFFF;
            end else begin
              sat_q <= 1'b0;
              res_q <= sum_w[31:0];
            end
            state_q <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (m_axis_tready) state_q <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid = (state_q == ST_OUT);
  assign m_axis_tdata  = {4'b0, pos_q[3:0], res_q};
  assign m_axis_tuser  = sat_q;

`ifndef SYNTHESIS
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped");
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !s_axis_tready)
    else $error("accept while result pending");
`endif
endmodule
